@@ design/skqt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skqt_pkg: shared types for the sorted keyed quantity table
// Operation and status codes, field types, the queued command record and
// the saturating add used by the update operation.
// ----------------------------------------------------------------------------
package skqt_pkg;

    localparam int KEY_W    = 32;
    localparam int QTY_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic signed [QTY_W-1:0] qty_t;

    // one classified command as it waits in the queue
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              is_dump;
        key_t              key;
        qty_t              amount;
    } cmd_t;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    // signed add clamped to the 32-bit range
    function automatic qty_t sat_add(input qty_t a, input qty_t b);
        logic signed [QTY_W:0] sum;
        qty_t                  res;
        sum = {a[QTY_W-1], a} + {b[QTY_W-1], b};
        if (sum[QTY_W] != sum[QTY_W-1])
        begin
            res = sum[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
        end
        else
        begin
            res = sum[QTY_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ design/skqt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skqt_if: command and response channels
// Valid/ready channels; a transaction moves when valid and ready are high
// at a rising clock edge.
// ----------------------------------------------------------------------------
interface skqt_cmd_if;
    import skqt_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    key_t              part_key;
    qty_t              amount;

    modport source (output valid, output mode, output part_key, output amount,
                    input ready);
    modport sink   (input valid, input mode, input part_key, input amount,
                    output ready);
endinterface

interface skqt_rsp_if;
    import skqt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    key_t                entry_key;
    qty_t                entry_quantity;
    logic                last;

    modport source (output valid, output status, output entry_key,
                    output entry_quantity, output last, input ready);
    modport sink   (input valid, input status, input entry_key,
                    input entry_quantity, input last, output ready);
endinterface

@@ design/skqt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skqt_front: command intake and queue
// Accepts command transactions, classifies dumps and holds up to two
// commands for the back end.
// ----------------------------------------------------------------------------
module skqt_front (
    input  logic              clk,
    input  logic              rst_n,
    skqt_cmd_if.sink          cmd,
    input  logic              pop,
    output skqt_pkg::q_head_t head
);
    import skqt_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    logic       take;
    cmd_t       incoming;

    // classify the incoming command
    always_comb
    begin
        incoming.mode    = cmd.mode;
        incoming.is_dump = (cmd.mode == MODE_DUMP);
        incoming.key     = cmd.part_key;
        incoming.amount  = cmd.amount;
    end

    assign cmd.ready = (fill_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign take      = pop && (fill_reg != 2'd0);

    assign head.valid = (fill_reg != 2'd0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !take)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (take && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

@@ design/skqt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skqt_back: sorted table engine
// A row of key/quantity cells kept in ascending order, compared in
// parallel; executes insert, search, update and dump into an output register.
// ----------------------------------------------------------------------------
module skqt_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  skqt_pkg::q_head_t head,
    output logic              pop,
    skqt_rsp_if.source        rsp
);
    import skqt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_EXE  = 3'd3;
    localparam logic [2:0] S_DUMP = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       dump_idx_reg, dump_idx_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [TABLE_DEPTH-1:0] match_reg, match_next;
    logic [TABLE_DEPTH-1:0] less_reg, less_next;
    logic                   hit_reg, hit_next;
    qty_t                   sel_q_reg, sel_q_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    key_t                   out_key_reg, out_key_next;
    qty_t                   out_qty_reg, out_qty_next;
    logic                   out_last_reg, out_last_next;

    key_t                   key_reg [TABLE_DEPTH];
    qty_t                   qty_reg [TABLE_DEPTH];
    key_t                   key_next [TABLE_DEPTH];
    qty_t                   qty_next [TABLE_DEPTH];
    key_t                   key_dn [TABLE_DEPTH];
    qty_t                   qty_dn [TABLE_DEPTH];
    key_t                   key_up [TABLE_DEPTH];
    qty_t                   qty_up [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] match_c;
    logic [TABLE_DEPTH-1:0] less_c;
    logic [TABLE_DEPTH-1:0] less_prev;
    qty_t                   sel_q_c;
    qty_t                   upd_q;
    logic                   slot_free;
    logic                   dump_last;
    logic                   do_insert;
    logic                   do_update;
    logic                   do_rotate;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.entry_key      = out_key_reg;
    assign rsp.entry_quantity = out_qty_reg;
    assign rsp.last           = out_last_reg;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign pop       = (state_reg == S_IDLE) && head.valid;
    assign upd_q     = sat_add(sel_q_reg, cmd_reg.amount);
    assign dump_last = (dump_idx_reg == count_reg - {{(CNT_W-1){1'b0}}, 1'b1});
    assign less_prev = {less_reg[TABLE_DEPTH-2:0], 1'b1};

    // neighbor taps of each cell
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_nbr
        if (g == 0)
        begin : g_first
            assign key_dn[g] = key_reg[g];
            assign qty_dn[g] = qty_reg[g];
        end
        else
        begin : g_mid
            assign key_dn[g] = key_reg[g-1];
            assign qty_dn[g] = qty_reg[g-1];
        end
        if (g == TABLE_DEPTH - 1)
        begin : g_top
            assign key_up[g] = key_reg[0];
            assign qty_up[g] = qty_reg[0];
        end
        else
        begin : g_low
            assign key_up[g] = key_reg[g+1];
            assign qty_up[g] = qty_reg[g+1];
        end
    end

    // parallel compare against every valid cell
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_c[i] = (CNT_W'(i) < count_reg) && (key_reg[i] == cmd_reg.key);
            less_c[i]  = (CNT_W'(i) < count_reg) && (key_reg[i] < cmd_reg.key);
        end
    end

    // one-hot select of the matching quantity
    always_comb
    begin
        sel_q_c = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sel_q_c = sel_q_c | (match_reg[i] ? qty_reg[i] : '0);
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        dump_idx_next   = dump_idx_reg;
        cmd_next        = cmd_reg;
        match_next      = match_reg;
        less_next       = less_reg;
        hit_next        = hit_reg;
        sel_q_next      = sel_q_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_qty_next    = out_qty_reg;
        out_last_next   = out_last_reg;
        do_insert       = 1'b0;
        do_update       = 1'b0;
        do_rotate       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    cmd_next      = head.cmd;
                    dump_idx_next = '0;
                    state_next    = head.cmd.is_dump ? S_EXE : S_CMP;
                end
            end
            S_CMP:
            begin
                match_next = match_c;
                less_next  = less_c;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                hit_next   = |match_reg;
                sel_q_next = sel_q_c;
                state_next = S_EXE;
            end
            S_EXE:
            begin
                if (slot_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_key_next    = cmd_reg.key;
                    out_qty_next    = '0;
                    out_status_next = ST_OK;
                    case (cmd_reg.mode)
                        MODE_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                out_status_next = ST_DUPLICATE;
                                out_qty_next    = sel_q_reg;
                            end
                            else if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                out_qty_next = cmd_reg.amount;
                                do_insert    = 1'b1;
                                count_next   = count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        MODE_SEARCH:
                        begin
                            if (hit_reg)
                            begin
                                out_qty_next = sel_q_reg;
                            end
                            else
                            begin
                                out_status_next = ST_NOT_FOUND;
                            end
                        end
                        MODE_UPDATE:
                        begin
                            if (hit_reg)
                            begin
                                out_qty_next = upd_q;
                                do_update    = 1'b1;
                            end
                            else
                            begin
                                out_status_next = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = ST_EMPTY;
                                out_key_next    = '0;
                            end
                            else
                            begin
                                // stream entries from the next state
                                out_valid_next = out_valid_reg && !rsp.ready;
                                out_last_next  = out_last_reg;
                                out_key_next   = out_key_reg;
                                out_qty_next   = out_qty_reg;
                                out_status_next = out_status_reg;
                                state_next     = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_key_next    = key_reg[0];
                    out_qty_next    = qty_reg[0];
                    out_last_next   = dump_last;
                    do_rotate       = 1'b1;
                    dump_idx_next   = dump_idx_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // per-cell next value: shift-insert, update in place, dump rotation
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            key_next[i] = key_reg[i];
            qty_next[i] = qty_reg[i];
            if (do_insert)
            begin
                if (!less_reg[i] && less_prev[i])
                begin
                    key_next[i] = cmd_reg.key;
                    qty_next[i] = cmd_reg.amount;
                end
                else if (!less_reg[i] && !less_prev[i] && (CNT_W'(i) <= count_reg))
                begin
                    key_next[i] = key_dn[i];
                    qty_next[i] = qty_dn[i];
                end
            end
            else if (do_update)
            begin
                if (match_reg[i])
                begin
                    qty_next[i] = upd_q;
                end
            end
            else if (do_rotate)
            begin
                if (CNT_W'(i) == count_reg - {{(CNT_W-1){1'b0}}, 1'b1})
                begin
                    key_next[i] = key_reg[0];
                    qty_next[i] = qty_reg[0];
                end
                else if (CNT_W'(i) < count_reg)
                begin
                    key_next[i] = key_up[i];
                    qty_next[i] = qty_up[i];
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers and table cells
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        match_reg      <= match_next;
        less_reg       <= less_next;
        hit_reg        <= hit_next;
        sel_q_reg      <= sel_q_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_qty_reg    <= out_qty_next;
        out_last_reg   <= out_last_next;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            key_reg[i] <= key_next[i];
            qty_reg[i] <= qty_next[i];
        end
    end

endmodule

@@ design/sorted_keyed_quantity_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_keyed_quantity_table: sorted key/quantity table
// Up to TABLE_DEPTH unique signed keys with signed quantities, kept in
// ascending key order, with insert, search, saturating update and dump.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command transaction (mode, part_key, amount); rsp carries
//   result transactions (status, entry_key, entry_quantity, last).
//   A two-entry command queue decouples intake from the table engine, so
//   commands are taken while a result waits in the output register.
//   Insert, search and update each give one result with last set. The engine
//   takes each through pop, parallel compare, select and execute in order and
//   loads the result register in execute; it pops the next command only
//   after execute, so the queue holds commands that arrive meanwhile.
//   A dump goes from pop straight to execute and then streams one entry per
//   cycle while rsp.ready stays high, in ascending key order, last set on the
//   final one; an empty table gives one result with status empty.
//   When the receiver holds rsp.ready low, the result register holds and
//   the engine waits; the queue keeps taking commands until it is full.
//   Reset clears the entry count, the queue and the output valid; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_keyed_quantity_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    skqt_cmd_if.sink   cmd,
    skqt_rsp_if.source rsp
);
    import skqt_pkg::*;

    q_head_t head;
    logic    pop;

    // command intake and queue
    skqt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .pop   (pop),
        .head  (head)
    );

    // table engine and result register
    skqt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

@@ design/skqt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skqt_checker: port-level checks for the sorted keyed quantity table
// Watches the response channel for handshake and result-format rules.
// ----------------------------------------------------------------------------
module skqt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [skqt_pkg::STATUS_W-1:0] rsp_status,
    input skqt_pkg::key_t                rsp_key,
    input skqt_pkg::qty_t                rsp_qty,
    input logic                          rsp_last
);
    import skqt_pkg::*;

    // stalled response stays valid
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response valid dropped while stalled");

    // stalled response keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable({rsp_status, rsp_key, rsp_qty, rsp_last}))
        else $error("response payload changed while stalled");

    // only a dump gives more than one result, and dump entries are ok
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_last)
        else $error("error result without last");

    // empty, not-found and full results carry no quantity
    a_fail_zero_qty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_NOT_FOUND ||
                      rsp_status == ST_FULL) |-> rsp_qty == '0)
        else $error("failure result with nonzero quantity");

endmodule

bind sorted_keyed_quantity_table skqt_checker u_skqt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_key    (rsp.entry_key),
    .rsp_qty    (rsp.entry_quantity),
    .rsp_last   (rsp.last)
);
